// File: design/srpq_pkg.sv
package srpq_pkg;

	localparam int PRIO_W  = 8;
	localparam int TAG_W   = 32;
	localparam int COUNT_W = 8;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_REMOVE
	} state_t;

endpackage

// File: design/sorted_ring_priority_queue_top.sv
// Channel   Direction  Signals                                      Transfer
// command   in         start, opcode, entry_priority, entry_tag     start && !busy
// result    out        done, status, out_priority, out_tag,         done (one cycle)
//                      entry_count
//
// Every command gives exactly one result, one cycle wide, on done.
// Full insert, empty insert and empty remove finish straight from idle; a remove first reads the head.
// Insert into a partly filled queue scans back from the tail and moves each larger entry one slot back,
// one per cycle over the single read and write port pair.
// Reset clears head, tail, count and the sequencer; the memory holds no reset, and data read from
// unoccupied slots is never used. The receiver cannot stall: results are never held.
module sorted_ring_priority_queue_top #(
	parameter int DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [srpq_pkg::PRIO_W-1:0]   entry_priority,
	input  logic [srpq_pkg::TAG_W-1:0]    entry_tag,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [srpq_pkg::PRIO_W-1:0]   out_priority,
	output logic [srpq_pkg::TAG_W-1:0]    out_tag,
	output logic [srpq_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam int CW = (OW > srpq_pkg::COUNT_W) ? OW : srpq_pkg::COUNT_W;
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

	// Step back one slot around the ring
	function automatic logic [IW-1:0] slot_before(input logic [IW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - IW'(1);
	endfunction

	// Step forward one slot around the ring
	function automatic logic [IW-1:0] slot_after(input logic [IW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + IW'(1);
	endfunction

	// Entry memory: one write port, one registered read port
	srpq_pkg::entry_t mem [DEPTH];
	srpq_pkg::entry_t rdata_q;

	srpq_pkg::state_t state_q, state_d;

	logic [IW-1:0] head_q, tail_q, pos_q;
	logic [OW-1:0] occ_q;
	logic [srpq_pkg::PRIO_W-1:0] prio_q;
	logic [srpq_pkg::TAG_W-1:0]  tag_q;

	logic done_q;
	logic [1:0] status_q;
	logic [srpq_pkg::PRIO_W-1:0] out_prio_q;
	logic [srpq_pkg::TAG_W-1:0]  out_tag_q;

	logic accept, is_full, is_empty, shift_more;
	logic [IW-1:0] npos;

	// Memory port and result controls
	logic we;
	logic [IW-1:0] waddr, raddr;
	srpq_pkg::entry_t wdata;
	logic fin;
	logic [1:0] fin_status;
	logic [srpq_pkg::PRIO_W-1:0] fin_prio;
	logic [srpq_pkg::TAG_W-1:0]  fin_tag;

	logic [CW-1:0] count_ext;

	assign busy       = (state_q != srpq_pkg::S_IDLE);
	assign accept     = start && !busy;
	assign is_full    = (occ_q == OW'(DEPTH));
	assign is_empty   = (occ_q == '0);
	// Entries strictly greater move back; equal ones stay ahead of the new entry
	assign shift_more = (rdata_q.prio > prio_q);
	assign npos       = slot_before(pos_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srpq_pkg::S_IDLE: begin
				if (accept) begin
					if (opcode == srpq_pkg::OP_REMOVE) begin
						if (!is_empty) state_d = srpq_pkg::S_REMOVE;
					end else if (!is_full && !is_empty) begin
						state_d = srpq_pkg::S_SCAN;
					end
				end
			end
			srpq_pkg::S_SCAN: begin
				if (shift_more) begin
					state_d = (npos == head_q) ? srpq_pkg::S_PLACE : srpq_pkg::S_SCAN;
				end else begin
					state_d = srpq_pkg::S_IDLE;
				end
			end
			srpq_pkg::S_PLACE:  state_d = srpq_pkg::S_IDLE;
			srpq_pkg::S_REMOVE: state_d = srpq_pkg::S_IDLE;
			default:            state_d = srpq_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory ports and result
	always_comb begin
		we         = 1'b0;
		waddr      = pos_q;
		wdata      = '{prio: prio_q, tag: tag_q};
		raddr      = npos;
		fin        = 1'b0;
		fin_status = srpq_pkg::STAT_OK;
		fin_prio   = '0;
		fin_tag    = '0;
		unique case (state_q)
			srpq_pkg::S_IDLE: begin
				// Read the head for a remove, the old tail for an insert
				raddr = (opcode == srpq_pkg::OP_REMOVE) ? head_q : tail_q;
				if (accept) begin
					if (opcode == srpq_pkg::OP_REMOVE) begin
						if (is_empty) begin
							fin        = 1'b1;
							fin_status = srpq_pkg::STAT_EMPTY;
						end
					end else if (is_full) begin
						fin        = 1'b1;
						fin_status = srpq_pkg::STAT_FULL;
					end else if (is_empty) begin
						we    = 1'b1;
						waddr = '0;
						wdata = '{prio: entry_priority, tag: entry_tag};
						fin   = 1'b1;
					end
				end
			end
			srpq_pkg::S_SCAN: begin
				if (shift_more) begin
					// Move the entry back and fetch the next one toward the head
					we    = 1'b1;
					wdata = rdata_q;
					raddr = slot_before(npos);
				end else begin
					we  = 1'b1;
					fin = 1'b1;
				end
			end
			srpq_pkg::S_PLACE: begin
				we  = 1'b1;
				fin = 1'b1;
			end
			srpq_pkg::S_REMOVE: begin
				fin      = 1'b1;
				fin_prio = rdata_q.prio;
				fin_tag  = rdata_q.tag;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srpq_pkg::S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			pos_q   <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			unique case (state_q)
				srpq_pkg::S_IDLE: begin
					if (accept && opcode == srpq_pkg::OP_INSERT && !is_full) begin
						occ_q <= occ_q + OW'(1);
						if (is_empty) begin
							head_q <= '0;
							tail_q <= '0;
							pos_q  <= '0;
						end else begin
							// Advance the tail; the scan starts from the new free slot
							tail_q <= slot_after(tail_q);
							pos_q  <= slot_after(tail_q);
						end
					end
				end
				srpq_pkg::S_SCAN: begin
					if (shift_more) pos_q <= npos;
				end
				srpq_pkg::S_REMOVE: begin
					occ_q <= occ_q - OW'(1);
					if (occ_q == OW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= slot_after(head_q);
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	// Hold the command payload for the scan and register the result fields when a command finishes
	always_ff @(posedge clk) begin
		if (accept) begin
			prio_q <= entry_priority;
			tag_q  <= entry_tag;
		end
		if (fin) begin
			status_q   <= fin_status;
			out_prio_q <= fin_prio;
			out_tag_q  <= fin_tag;
		end
	end

	assign count_ext    = CW'(occ_q);
	assign done         = done_q;
	assign status       = status_q;
	assign out_priority = out_prio_q;
	assign out_tag      = out_tag_q;
	assign entry_count  = count_ext[srpq_pkg::COUNT_W-1:0];

endmodule

// File: dv/sorted_ring_priority_queue_top_test.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic [1:0]                   status;
	logic [srpq_pkg::PRIO_W-1:0]  prio;
	logic [srpq_pkg::TAG_W-1:0]   tag;
	logic [srpq_pkg::COUNT_W-1:0] count;
} queue_result_t;

class queue_scoreboard;
	int                depth;
	int                mismatches;
	srpq_pkg::entry_t  held_entries[$];
	queue_result_t     pending_results[$];

	function new(int depth_i);
		depth = depth_i;
		mismatches = 0;
	endfunction

	task report(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Keep the held entries sorted by ascending priority, ties in arrival order.
	function void note_command(logic op, logic [srpq_pkg::PRIO_W-1:0] prio,
			logic [srpq_pkg::TAG_W-1:0] tag);
		queue_result_t    res;
		srpq_pkg::entry_t ent;
		int               pos;
		res = '0;
		if (op == srpq_pkg::OP_INSERT) begin
			if (held_entries.size() >= depth) begin
				res.status = srpq_pkg::STAT_FULL;
			end else begin
				pos = held_entries.size();
				while (pos > 0 && held_entries[pos-1].prio > prio)
					pos--;
				ent.prio = prio;
				ent.tag = tag;
				held_entries.insert(pos, ent);
				res.status = srpq_pkg::STAT_OK;
			end
		end else if (held_entries.size() == 0) begin
			res.status = srpq_pkg::STAT_EMPTY;
		end else begin
			ent = held_entries.pop_front();
			res.status = srpq_pkg::STAT_OK;
			res.prio = ent.prio;
			res.tag = ent.tag;
		end
		res.count = srpq_pkg::COUNT_W'(held_entries.size());
		pending_results.push_back(res);
	endfunction

	task check_result(queue_result_t got);
		queue_result_t want;
		if (pending_results.size() == 0) begin
			report("result with no command waiting");
		end else begin
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.prio !== want.prio)
				report($sformatf("out_priority %0d, want %0d", got.prio, want.prio));
			if (got.tag !== want.tag)
				report($sformatf("out_tag %h, want %h", got.tag, want.tag));
			if (got.count !== want.count)
				report($sformatf("entry_count %0d, want %0d", got.count, want.count));
		end
	endtask
endclass

module sorted_ring_priority_queue_top_test;

	localparam int DEPTH      = 128;
	localparam int SEGMENTS   = 10;
	localparam int SEG_ITEMS  = 200;
	localparam int DRAIN_MAX  = 20000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           opcode = srpq_pkg::OP_INSERT;
	logic [srpq_pkg::PRIO_W-1:0]    entry_priority = '0;
	logic [srpq_pkg::TAG_W-1:0]     entry_tag = '0;
	logic                           busy;
	logic                           done;
	logic [1:0]                     status;
	logic [srpq_pkg::PRIO_W-1:0]    out_priority;
	logic [srpq_pkg::TAG_W-1:0]     out_tag;
	logic [srpq_pkg::COUNT_W-1:0]   entry_count;

	// Percent chance per cycle that the sender holds off after a transfer.
	int                   idle_pct = 0;
	queue_scoreboard      sb = new(DEPTH);

	sorted_ring_priority_queue_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_priority(entry_priority),
		.entry_tag(entry_tag),
		.done(done),
		.status(status),
		.out_priority(out_priority),
		.out_tag(out_tag),
		.entry_count(entry_count)
	);

	always #6 clk = ~clk;

	// Bound the whole run, well above the slowest legal run with the longest gaps.
	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	// Sample both channels at the edge. Note the command first: the expectation
	// queue is in order, so the check still pops the oldest one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_command(opcode, entry_priority, entry_tag);
			if (done)
				sb.check_result('{status, out_priority, out_tag, entry_count});
		end
	end

	// Present one command and hold it until the block takes it. Afterwards, idle
	// for a random number of cycles; with no idle cycle, start stays high so the
	// next command follows back to back.
	task automatic send_command(input logic op,
			input logic [srpq_pkg::PRIO_W-1:0] prio,
			input logic [srpq_pkg::TAG_W-1:0] tag);
		bit lowered;
		lowered = 1'b0;
		start <= 1'b1;
		opcode <= op;
		entry_priority <= prio;
		entry_tag <= tag;
		do
			@(posedge clk);
		while (busy);
		while ($urandom_range(99) < idle_pct) begin
			if (!lowered) begin
				start <= 1'b0;
				opcode <= 1'($urandom);
				entry_priority <= srpq_pkg::PRIO_W'($urandom);
				entry_tag <= $urandom;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
	endtask

	// Mix tight priority ranges, so ties and long shifts are common, with the
	// full range so every priority bit toggles.
	task automatic send_random(input int insert_bias);
		logic                        op;
		logic [srpq_pkg::PRIO_W-1:0] prio;
		op = ($urandom_range(99) < insert_bias) ? srpq_pkg::OP_INSERT : srpq_pkg::OP_REMOVE;
		case ($urandom_range(3))
			0: prio = srpq_pkg::PRIO_W'($urandom_range(3));
			1: prio = srpq_pkg::PRIO_W'($urandom_range(15));
			default: prio = srpq_pkg::PRIO_W'($urandom_range(255));
		endcase
		send_command(op, prio, $urandom);
	endtask

	initial begin
		int bias_cycle[5];
		int idle_cycle[3];
		int waited;
		bias_cycle = '{90, 10, 55, 88, 20};
		idle_cycle = '{0, 84, 37};
		waited = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty remove, field extremes, equal priorities in arrival
		// order, drain to empty, then refill the emptied queue from slot zero.
		send_command(srpq_pkg::OP_REMOVE, 8'd0, 32'd0);
		send_command(srpq_pkg::OP_INSERT, 8'd0, 32'h0000_0000);
		send_command(srpq_pkg::OP_REMOVE, 8'd0, 32'd0);
		send_command(srpq_pkg::OP_INSERT, 8'd255, 32'hFFFF_FFFF);
		send_command(srpq_pkg::OP_INSERT, 8'd255, 32'h0000_0001);
		send_command(srpq_pkg::OP_INSERT, 8'd255, 32'h0000_0002);
		send_command(srpq_pkg::OP_INSERT, 8'd0, 32'hAAAA_AAAA);
		send_command(srpq_pkg::OP_INSERT, 8'd128, 32'h5555_5555);
		send_command(srpq_pkg::OP_INSERT, 8'd0, 32'h0000_0003);
		repeat (6) send_command(srpq_pkg::OP_REMOVE, 8'hFF, 32'hFFFF_FFFF);
		send_command(srpq_pkg::OP_REMOVE, 8'd0, 32'd0);
		send_command(srpq_pkg::OP_INSERT, 8'd7, 32'h1234_5678);
		send_command(srpq_pkg::OP_INSERT, 8'd3, 32'h8765_4321);
		send_command(srpq_pkg::OP_INSERT, 8'd9, 32'h0F0F_0F0F);
		send_command(srpq_pkg::OP_INSERT, 8'd3, 32'hF0F0_F0F0);
		repeat (4) send_command(srpq_pkg::OP_REMOVE, 8'd0, 32'd0);

		// Random: alternate fill-heavy and drain-heavy segments so the queue
		// hits both full and empty, and rotate the sender idle rate.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			idle_pct = idle_cycle[seg % 3];
			repeat (SEG_ITEMS) send_random(bias_cycle[seg % 5]);
		end
		start <= 1'b0;

		// Drain: wait for every expected result, then allow one worst-case insert.
		while (sb.pending_results.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (DEPTH + 4) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
